### sv/rbos_pkg.sv
`default_nettype none

package rbos_pkg;

  localparam int SECTORS    = 18;
  localparam int MAX_POINTS = 1024;
  localparam int HALF       = SECTORS / 2;

  localparam int AZ_W  = 17;
  localparam int RNG_W = 16;
  localparam int RAD_W = 16;
  localparam int OFF_W = AZ_W + 1;
  localparam int WS_W  = 48;
  localparam int WT_W  = 27;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SEC_W = $clog2(SECTORS);
  localparam int TST_W = 28;

  localparam int DIV_NW = WS_W;
  localparam int DIV_DW = WT_W;
  localparam int DIV_QW = AZ_W;
  localparam int DIV_KW = $clog2(DIV_QW);

  localparam int CFG_IW = 2;
  localparam int CFG_DW = AZ_W;

  localparam logic [CFG_IW-1:0] REG_ARC_START = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ARC_END   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BUB_MIN   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_BUB_MAX   = 2'd3;

  localparam logic [AZ_W-1:0]  RST_ARC_START = 17'sd0;
  localparam logic [AZ_W-1:0]  RST_ARC_END   = 17'sd18000;
  localparam logic [RAD_W-1:0] RST_BUB_MIN   = 16'd400;
  localparam logic [RAD_W-1:0] RST_BUB_MAX   = 16'd800;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_KW-1:0] top_k;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WORK = 7'b0000010,
    S_RAD  = 7'b0000100,
    S_CMP  = 7'b0001000,
    S_END  = 7'b0010000,
    S_FDIV = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### sv/rbos_div.sv
`default_nettype none

module rbos_div (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire rbos_pkg::div_req_t req,
  output rbos_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic [rbos_pkg::DIV_NW-1:0] rem_r, rem_nxt;
  logic [rbos_pkg::DIV_NW-1:0] dsh_r, dsh_nxt;
  logic [rbos_pkg::DIV_QW-1:0] quo_r, quo_nxt;
  logic [rbos_pkg::DIV_KW-1:0] k_r, k_nxt;
  logic                        ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    k_nxt    = k_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.num;
      dsh_nxt  = rbos_pkg::DIV_NW'(req.den) << req.top_k;
      quo_nxt  = '0;
      k_nxt    = req.top_k;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[rbos_pkg::DIV_QW-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (k_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    k_r   <= k_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

### sv/rbos_mac.sv
`default_nettype none

module rbos_mac (
  input  wire                        logic clk,
  input  wire                        logic rst_n,
  input  wire rbos_pkg::mac_ctl_t    ctl,
  input  wire logic [rbos_pkg::AZ_W-1:0]  az,
  input  wire logic [rbos_pkg::RNG_W-1:0] rng,
  output logic                       busy,
  output logic [rbos_pkg::WS_W-1:0]  wsum,
  output logic [rbos_pkg::WT_W-1:0]  wtsum
);

  localparam int CW = $clog2(rbos_pkg::RNG_W);

  logic                         busy_r, busy_nxt;
  logic [rbos_pkg::WS_W-1:0]    wsum_r, wsum_nxt;
  logic [rbos_pkg::WT_W-1:0]    wtsum_r, wtsum_nxt;
  logic [rbos_pkg::WS_W-1:0]    mcand_r, mcand_nxt;
  logic [rbos_pkg::RNG_W-1:0]   mplier_r, mplier_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    wsum_nxt   = wsum_r;
    wtsum_nxt  = wtsum_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    if (ctl.clear) begin
      wsum_nxt  = '0;
      wtsum_nxt = '0;
    end else if (ctl.start) begin
      busy_nxt   = 1'b1;
      mcand_nxt  = {{(rbos_pkg::WS_W-rbos_pkg::AZ_W){az[rbos_pkg::AZ_W-1]}}, az};
      mplier_nxt = rng;
      cnt_nxt    = CW'(rbos_pkg::RNG_W - 1);
      wtsum_nxt  = wtsum_r + rbos_pkg::WT_W'(rng);
    end else if (busy_r) begin
      // one multiplier bit per cycle
      if (mplier_r[0]) begin
        wsum_nxt = wsum_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      wsum_r  <= '0;
      wtsum_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      wsum_r  <= wsum_nxt;
      wtsum_r <= wtsum_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign busy  = busy_r;
  assign wsum  = wsum_r;
  assign wtsum = wtsum_r;

endmodule

`default_nettype wire

### sv/bubble_obstacle_steering_top.sv
// Bubble rebound obstacle steering.
// Input stream: one laser scan point per word. in_tdata carries azimuth and
// range, in_tlast marks the last point of a scan. Output stream: one word per
// scan, sent after the last point, carrying the steering angle in out_tdata
// and the obstacle and zero-weight flags in out_tuser.
// Configuration: cfg_valid/cfg_index/cfg_data write the arc limits and bubble
// radii; cfg_ready is always high. Write only while no scan point is in work.
// Pacing: in_tready stays low from a point's acceptance until its work is done:
// the bit-serial multiply of azimuth by range, with the sector divide beside it
// on the shared serial divider, and then the bubble test for a point in the arc.
// Scan end: when an obstacle was found and the weight is nonzero, the last point
// adds a serial divide for the weighted mean before its result is registered.
// Points beyond the per-scan limit are dropped, but a last point still ends
// the scan. Reset restores the default arc and radii and clears the scan.
// A result waits in the output register while out_tready is low; the next
// points are still accepted, and only a further scan end waits for the slot.
`default_nettype none

module bubble_obstacle_steering_top (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_tvalid,
  output logic              in_tready,
  input  wire  logic [39:0] in_tdata,   // azimuth[16:0], range_mm[32:17], zero pad
  input  wire  logic        in_tlast,
  output logic              out_tvalid,
  input  wire  logic        out_tready,
  output logic [23:0]       out_tdata,  // steer_angle[16:0], zero pad
  output logic [1:0]        out_tuser,  // obstacle_found[0], zero_weight[1]
  input  wire  logic        cfg_valid,
  output logic              cfg_ready,
  input  wire  logic [rbos_pkg::CFG_IW-1:0] cfg_index,
  input  wire  logic [rbos_pkg::CFG_DW-1:0] cfg_data
);

  localparam int AW  = rbos_pkg::AZ_W;
  localparam int RW  = rbos_pkg::RAD_W;
  localparam int OW  = rbos_pkg::OFF_W;
  localparam int SW  = rbos_pkg::SEC_W;
  localparam int TW  = rbos_pkg::TST_W;
  localparam int CW  = rbos_pkg::CNT_W;
  localparam int NW  = rbos_pkg::DIV_NW;
  localparam int QW  = rbos_pkg::DIV_QW;

  // configuration
  logic [AW-1:0] arc_start_r, arc_end_r;
  logic [RW-1:0] bub_min_r, bub_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_start_r <= rbos_pkg::RST_ARC_START;
      arc_end_r   <= rbos_pkg::RST_ARC_END;
      bub_min_r   <= rbos_pkg::RST_BUB_MIN;
      bub_max_r   <= rbos_pkg::RST_BUB_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbos_pkg::REG_ARC_START: arc_start_r <= cfg_data;
        rbos_pkg::REG_ARC_END:   arc_end_r   <= cfg_data;
        rbos_pkg::REG_BUB_MIN:   bub_min_r   <= cfg_data[RW-1:0];
        rbos_pkg::REG_BUB_MAX:   bub_max_r   <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [AW-1:0]             in_az;
  logic [rbos_pkg::RNG_W-1:0] in_rng;
  assign in_az  = in_tdata[AW-1:0];
  assign in_rng = in_tdata[AW+rbos_pkg::RNG_W-1:AW];

  logic signed [OW-1:0] az_s, st_s, en_s;
  logic [OW-1:0]        off_w, span_w;
  logic                 in_arc;

  assign az_s   = $signed({in_az[AW-1], in_az});
  assign st_s   = $signed({arc_start_r[AW-1], arc_start_r});
  assign en_s   = $signed({arc_end_r[AW-1], arc_end_r});
  assign off_w  = OW'(az_s - st_s);
  assign span_w = OW'(en_s - st_s);
  assign in_arc = (en_s > st_s) && (az_s >= st_s) && (az_s < en_s);

  // units
  rbos_pkg::div_req_t div_req;
  rbos_pkg::div_rsp_t div_rsp;
  rbos_pkg::mac_ctl_t mac_ctl;
  logic                      mac_busy;
  logic [rbos_pkg::WS_W-1:0] wsum;
  logic [rbos_pkg::WT_W-1:0] wtsum;

  rbos_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rbos_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .az    (in_az),
    .rng   (in_rng),
    .busy  (mac_busy),
    .wsum  (wsum),
    .wtsum (wtsum)
  );

  // control
  rbos_pkg::state_t state_r, state_nxt;
  logic                       hit_r, hit_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       last_r, last_nxt;
  logic                       tst_r, tst_nxt;
  logic [rbos_pkg::RNG_W-1:0] rng_r, rng_nxt;
  logic signed [TW-1:0]       prod_r, prod_nxt;
  logic                       neg_r, neg_nxt;
  logic                       zw_r, zw_nxt;
  logic [AW-1:0]              ang_r, ang_nxt;
  logic                       ov_r, ov_nxt;
  logic [AW-1:0]              o_ang_r, o_ang_nxt;
  logic                       o_obs_r, o_obs_nxt;
  logic                       o_zw_r, o_zw_nxt;

  logic                  accept, take;
  logic [SW-1:0]         sec_w, mir_w, d_w;
  logic signed [TW-1:0]  d_ext, diff_ext, lhs_w, rhs_w;
  logic [NW-1:0]         mag_w;
  logic [QW-1:0]         quo_w;

  assign in_tready = (state_r == rbos_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign take      = (cnt_r < CW'(rbos_pkg::MAX_POINTS));

  // sector distance from the nearer arc edge
  always_comb begin
    sec_w = div_rsp.quo[SW-1:0];
    if (sec_w > SW'(rbos_pkg::SECTORS - 1)) begin
      sec_w = SW'(rbos_pkg::SECTORS - 1);
    end
    mir_w = SW'(rbos_pkg::SECTORS - 1) - sec_w;
    d_w   = (sec_w < mir_w) ? sec_w : mir_w;
    if (d_w > SW'(rbos_pkg::HALF - 1)) begin
      d_w = SW'(rbos_pkg::HALF - 1);
    end
  end

  assign d_ext    = $signed({{(TW-SW){1'b0}}, d_w});
  assign diff_ext = $signed(TW'({1'b0, bub_max_r}) - TW'({1'b0, bub_min_r}));
  assign lhs_w    = $signed(TW'(rng_r) * TW'(rbos_pkg::HALF - 1));
  assign rhs_w    = $signed(TW'(bub_min_r) * TW'(rbos_pkg::HALF - 1)) + prod_r;
  assign mag_w    = wsum[NW-1] ? NW'(-wsum) : wsum;
  assign quo_w    = div_rsp.quo;

  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    tst_nxt   = tst_r;
    rng_nxt   = rng_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    zw_nxt    = zw_r;
    ang_nxt   = ang_r;
    ov_nxt    = ov_r;
    o_ang_nxt = o_ang_r;
    o_obs_nxt = o_obs_r;
    o_zw_nxt  = o_zw_r;
    div_req   = '0;
    mac_ctl   = '0;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      rbos_pkg::S_IDLE: begin
        if (accept) begin
          last_nxt = in_tlast;
          rng_nxt  = in_rng;
          tst_nxt  = 1'b0;
          if (take) begin
            cnt_nxt       = cnt_r + 1'b1;
            mac_ctl.start = 1'b1;
            tst_nxt       = in_arc;
            if (in_arc) begin
              div_req.start = 1'b1;
              div_req.num   = NW'(off_w) * NW'(rbos_pkg::SECTORS);
              div_req.den   = rbos_pkg::DIV_DW'(span_w);
              div_req.top_k = rbos_pkg::DIV_KW'(SW - 1);
            end
            state_nxt = rbos_pkg::S_WORK;
          end else begin
            state_nxt = rbos_pkg::S_END;
          end
        end
      end
      rbos_pkg::S_WORK: begin
        if (!mac_busy && !div_rsp.busy) begin
          state_nxt = tst_r ? rbos_pkg::S_RAD : rbos_pkg::S_END;
        end
      end
      rbos_pkg::S_RAD: begin
        prod_nxt  = TW'(d_ext * diff_ext);
        state_nxt = rbos_pkg::S_CMP;
      end
      rbos_pkg::S_CMP: begin
        if (lhs_w < rhs_w) begin
          hit_nxt = 1'b1;
        end
        state_nxt = rbos_pkg::S_END;
      end
      rbos_pkg::S_END: begin
        if (!last_r) begin
          state_nxt = rbos_pkg::S_IDLE;
        end else begin
          zw_nxt  = (wtsum == '0);
          neg_nxt = wsum[NW-1];
          ang_nxt = '0;
          if (hit_r && (wtsum != '0)) begin
            div_req.start = 1'b1;
            div_req.num   = mag_w;
            div_req.den   = wtsum;
            div_req.top_k = rbos_pkg::DIV_KW'(QW - 1);
            state_nxt     = rbos_pkg::S_FDIV;
          end else begin
            state_nxt = rbos_pkg::S_OUT;
          end
        end
      end
      rbos_pkg::S_FDIV: begin
        if (!div_rsp.busy) begin
          ang_nxt   = neg_r ? AW'(-quo_w) : AW'(quo_w);
          state_nxt = rbos_pkg::S_OUT;
        end
      end
      rbos_pkg::S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt        = 1'b1;
          o_ang_nxt     = ang_r;
          o_obs_nxt     = hit_r;
          o_zw_nxt      = zw_r;
          hit_nxt       = 1'b0;
          cnt_nxt       = '0;
          mac_ctl.clear = 1'b1;
          state_nxt     = rbos_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rbos_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbos_pkg::S_IDLE;
      hit_r   <= 1'b0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hit_r   <= hit_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    last_r  <= last_nxt;
    tst_r   <= tst_nxt;
    rng_r   <= rng_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    zw_r    <= zw_nxt;
    ang_r   <= ang_nxt;
    o_ang_r <= o_ang_nxt;
    o_obs_r <= o_obs_nxt;
    o_zw_r  <= o_zw_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(24-AW){1'b0}}, o_ang_r};
  assign out_tuser  = {o_zw_r, o_obs_r};

endmodule

`default_nettype wire

### bench/bubble_obstacle_steering_checker.sv
`timescale 1ns / 100ps

module bubble_obstacle_steering_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [39:0]                   in_tdata,   // azimuth[16:0], range_mm[32:17]
  input  wire logic                          in_tlast,
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [23:0]                   out_tdata,  // steer_angle[16:0]
  input  wire logic [1:0]                    out_tuser,  // obstacle_found[0], zero_weight[1]
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [rbos_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [rbos_pkg::CFG_DW-1:0]   cfg_data,
  output int                                 fail_count,
  output int                                 pending_count
);
  import rbos_pkg::*;

  typedef struct {
    logic            obstacle;
    logic [AZ_W-1:0] angle;
    logic            zero_w;
  } steer_word_t;

  steer_word_t steer_words_due[$];

  longint arc_lo, arc_hi, rad_outer, rad_center;
  logic   hit_seen;
  longint moment_sum, range_sum;
  int     points_taken;
  int     words_seen;

  function automatic logic point_in_bubble(longint az, longint rng);
    longint span, sec, d;
    span = arc_hi - arc_lo;
    if (span <= 0 || az < arc_lo || az >= arc_hi) return 1'b0;
    sec = ((az - arc_lo) * SECTORS) / span;
    if (sec > SECTORS - 1) sec = SECTORS - 1;
    d = (sec < SECTORS - 1 - sec) ? sec : SECTORS - 1 - sec;
    if (d > HALF - 1) d = HALF - 1;
    return rng * (HALF - 1) < rad_outer * (HALF - 1) + d * (rad_center - rad_outer);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] word %0d: %s mismatch, got %0d want %0d", $time, words_seen, what, got,
             want);
    fail_count++;
  endtask

  task automatic clear_scan();
    hit_seen     = 1'b0;
    moment_sum   = 0;
    range_sum    = 0;
    points_taken = 0;
  endtask

  task automatic take_point(input logic [39:0] data, input logic last);
    longint      az, rng, quo;
    steer_word_t w;
    az  = longint'($signed(data[AZ_W-1:0]));
    rng = longint'(data[AZ_W+RNG_W-1:AZ_W]);
    if (points_taken < MAX_POINTS) begin
      points_taken++;
      if (point_in_bubble(az, rng)) hit_seen = 1'b1;
      moment_sum += az * rng;
      range_sum  += rng;
    end
    if (last) begin
      w.obstacle = hit_seen;
      w.zero_w   = (range_sum == 0);
      quo        = (hit_seen && range_sum != 0) ? moment_sum / range_sum : 0;
      w.angle    = quo[AZ_W-1:0];
      steer_words_due.push_back(w);
      clear_scan();
    end
  endtask

  task automatic check_word(input logic [23:0] data, input logic [1:0] user);
    steer_word_t w;
    if (steer_words_due.size() == 0) begin
      report_mismatch("unexpected word", longint'($signed(data[AZ_W-1:0])), 0);
    end else begin
      w = steer_words_due.pop_front();
      if (user[0] !== w.obstacle) report_mismatch("obstacle_found", user[0], w.obstacle);
      if (data[AZ_W-1:0] !== w.angle)
        report_mismatch("steer_angle", $signed(data[AZ_W-1:0]), $signed(w.angle));
      if (user[1] !== w.zero_w) report_mismatch("zero_weight", user[1], w.zero_w);
    end
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      arc_lo     = longint'($signed(RST_ARC_START));
      arc_hi     = longint'($signed(RST_ARC_END));
      rad_outer  = longint'(RST_BUB_MIN);
      rad_center = longint'(RST_BUB_MAX);
      clear_scan();
      steer_words_due.delete();
      fail_count = 0;
      words_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ARC_START: arc_lo     = longint'($signed(cfg_data));
          REG_ARC_END:   arc_hi     = longint'($signed(cfg_data));
          REG_BUB_MIN:   rad_outer  = longint'(cfg_data[RAD_W-1:0]);
          REG_BUB_MAX:   rad_center = longint'(cfg_data[RAD_W-1:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_point(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_word(out_tdata, out_tuser);
    end
    pending_count = steer_words_due.size();
  end

endmodule

### bench/bubble_obstacle_steering_top_tb.sv
`timescale 1ns / 100ps

module bubble_obstacle_steering_top_tb;
  import rbos_pkg::*;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;   // azimuth[16:0], range_mm[32:17], zero pad
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;         // steer_angle[16:0], zero pad
  logic [1:0]        out_tuser;         // obstacle_found[0], zero_weight[1]
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index  = '0;
  logic [CFG_DW-1:0] cfg_data   = '0;

  int fail_count;
  int pending_count;
  int tx_idle_pct = 28;
  int rx_idle_pct = 86;
  int cur_start, cur_end, cur_min, cur_max;

  always #1 clk = ~clk;

  bubble_obstacle_steering_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bubble_obstacle_steering_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_point(input int az, input int rng, input bit last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, 16'(rng), 17'(az)};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_config(input int s, input int e, input int mn, input int mx);
    cur_start = s;
    cur_end   = e;
    cur_min   = mn;
    cur_max   = mx;
    cfg_valid <= 1'b1;
    cfg_index <= REG_ARC_START;
    cfg_data  <= 17'(s);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_ARC_END;
    cfg_data  <= 17'(e);
    do @(posedge clk); while (!cfg_ready);
    // top bit of a radius word is ignored by the block
    cfg_index <= REG_BUB_MIN;
    cfg_data  <= {1'($urandom_range(0, 1)), 16'(mn)};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BUB_MAX;
    cfg_data  <= {1'($urandom_range(0, 1)), 16'(mx)};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_scans(input int n_items);
    int sent, len, span, rtop, az, rng, k, pick;
    bit silent;
    sent = 0;
    span = cur_end - cur_start;
    rtop = (cur_min > cur_max) ? cur_min : cur_max;
    rtop = rtop + rtop / 4 + 16;
    if (rtop > 65535) rtop = 65535;
    while (sent < n_items) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      silent = ($urandom_range(0, 11) == 0);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70 && span > 0) begin
          az = cur_start + $urandom_range(0, span - 1);
        end else if (pick < 85) begin
          az = $urandom_range(0, 72000) - 36000;
        end else if (pick < 93) begin
          az = $urandom_range(0, 1) ? 36000 : -36000;
        end else begin
          case ($urandom_range(0, 3))
            0:       az = cur_start - 1;
            1:       az = cur_start;
            2:       az = cur_end - 1;
            default: az = cur_end;
          endcase
        end
        if (az < -36000) az = -36000;
        if (az > 36000) az = 36000;
        pick = $urandom_range(0, 99);
        if (silent || pick < 8) rng = 0;
        else if (pick < 60) rng = $urandom_range(0, rtop);
        else if (pick < 90) rng = $urandom_range(0, 65535);
        else rng = 65535;
        send_point(az, rng, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int s, e;
    cur_start = 0;
    cur_end   = 18000;
    cur_min   = 400;
    cur_max   = 800;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default arc 0..18000, radii 400..800, sectors of 1000
    send_point(0, 399, 1'b0);
    send_point(17999, 399, 1'b0);
    send_point(8500, 799, 1'b0);
    send_point(8500, 800, 1'b0);
    send_point(-1, 0, 1'b0);
    send_point(18000, 0, 1'b0);
    send_point(-36000, 65535, 1'b0);
    send_point(36000, 65535, 1'b1);
    send_point(9000, 65535, 1'b1);
    send_point(4500, 0, 1'b1);
    send_point(-36000, 0, 1'b0);
    send_point(36000, 0, 1'b1);
    send_point(100, 100, 1'b0);
    send_point(-36000, 65535, 1'b0);
    send_point(35999, 1, 1'b1);
    send_point(3000, 550, 1'b0);
    send_point(3000, 549, 1'b1);
    send_point(12000, 600, 1'b1);
    drain();

    write_config(-36000, 36000, 0, 65535);
    random_scans(145);
    drain();
    write_config(-9000, 9000, 800, 200);
    random_scans(145);
    drain();

    tx_idle_pct = 86;
    rx_idle_pct = 28;
    s = $urandom_range(0, 60000) - 36000;
    e = s + $urandom_range(1, 36000 - s);
    write_config(s, e, $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_scans(145);
    drain();
    write_config(36000, -36000, 500, 900);
    random_scans(145);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(-36000, -35983, 65535, 65535);
    random_scans(145);
    drain();
    s = $urandom_range(0, 60000) - 36000;
    e = s + $urandom_range(1, 36000 - s);
    write_config(s, e, $urandom_range(0, 3000), $urandom_range(0, 3000));
    random_scans(145);
    drain();

    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
